/* sv/csvcs_pkg.sv */
package csvcs_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  localparam int CELL_OFFSET_W = 32;
  localparam int CELL_LENGTH_W = 32;
  localparam int COLUMN_W      = 6;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_DELIM,
    CLS_EOL
  } csvcs_cls_t;

  typedef enum logic [1:0] {
    STATUS_CELL,
    STATUS_TOO_MANY,
    STATUS_NO_EOL
  } csvcs_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } csvcs_byte_t;

  typedef struct packed {
    logic [CELL_OFFSET_W-1:0] cell_offset;
    logic [CELL_LENGTH_W-1:0] cell_length;
    logic [COLUMN_W-1:0]      column_index;
    logic                     row_end;
    csvcs_status_t            status;
  } csvcs_cell_t;

  typedef struct packed {
    csvcs_cls_t cls;
    logic       eof;
  } csvcs_tok_t;

  typedef struct packed {
    logic       valid;
    csvcs_tok_t tok;
  } csvcs_slot_t;

endpackage

/* sv/csv_cell_splitter.sv */
// Path: each byte is written into the queue; a cell that it completes is registered at the output when it is popped.
// Throughput: one byte per cycle while the queue is not full, set by the row and cell update in the back end.
// The queue, two entries deep by default, absorbs output stall until it is full; then the input stalls.
// Reset (rst, synchronous): empties the queue, clears position, row state and the error halt,
// drops any pending cell and sets the delimiter back to a comma.
module csv_cell_splitter
  import csvcs_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        delim_we,
  input  logic [7:0]  delim_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  csvcs_byte_t byte_req,
  output logic        cell_valid,
  input  logic        cell_stall,
  output csvcs_cell_t cell_req
);

  csvcs_slot_t push;
  csvcs_slot_t head;
  logic        full;
  logic        pop;

  assign byte_stall = full;

  csvcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .delim_we   (delim_we),
    .delim_data (delim_data),
    .byte_valid (byte_valid),
    .byte_req   (byte_req),
    .full       (full),
    .push       (push)
  );

  csvcs_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  csvcs_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_req   (cell_req)
  );

endmodule

/* sv/csvcs_front.sv */
module csvcs_front
  import csvcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        delim_we,
  input  logic [7:0]  delim_data,
  input  logic        byte_valid,
  input  csvcs_byte_t byte_req,
  input  logic        full,
  output csvcs_slot_t push
);

  logic [7:0] delimiter;
  logic       line_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (delim_we) begin
      delimiter <= delim_data;
    end
  end

  assign line_end = (byte_req.data_byte == BYTE_CR) || (byte_req.data_byte == BYTE_LF);

  always_comb begin
    push.valid   = byte_valid && !full;
    push.tok.eof = byte_req.end_of_file;
    if (line_end) begin
      push.tok.cls = CLS_EOL;
    end else if (byte_req.data_byte == delimiter) begin
      push.tok.cls = CLS_DELIM;
    end else begin
      push.tok.cls = CLS_DATA;
    end
  end

endmodule

/* sv/csvcs_fifo.sv */
module csvcs_fifo
  import csvcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  csvcs_slot_t push,
  input  logic        pop,
  output csvcs_slot_t head,
  output logic        full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  csvcs_tok_t    mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.tok   = mem[rd_ptr];

endmodule

/* sv/csvcs_back.sv */
module csvcs_back
  import csvcs_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  csvcs_slot_t head,
  output logic        pop,
  output logic        cell_valid,
  input  logic        cell_stall,
  output csvcs_cell_t cell_req
);

  localparam int CNW = $clog2(MAX_COLUMNS + 1);

  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] open_start;
  logic [CNW-1:0]         cells_in_row;
  logic                   inside_row;
  logic                   halted;

  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [OFFSET_BITS-1:0] open_start_next;
  logic [CNW-1:0]         cells_in_row_next;
  logic                   inside_row_next;
  logic                   halted_next;

  logic                   line_end;
  logic                   delim;
  logic                   start_row;
  logic                   row_open;
  logic                   have_cell;
  logic                   still_open;
  logic                   too_many;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] pos1;
  logic [CNW-1:0]         cnt;
  logic [CNW-1:0]         cnt1;
  logic                   emit;
  csvcs_cell_t            result;

  assign pop = head.valid && (!cell_valid || !cell_stall);

  always_comb begin
    line_end   = (head.tok.cls == CLS_EOL);
    delim      = (head.tok.cls == CLS_DELIM);
    start_row  = !inside_row && !line_end;
    row_open   = inside_row || start_row;
    start      = start_row ? byte_position : open_start;
    cnt        = start_row ? '0 : cells_in_row;
    have_cell  = row_open && (line_end || delim);
    still_open = row_open && !line_end;
    pos1       = byte_position + 1'b1;
    cnt1       = cnt + 1'b1;
    too_many   = have_cell && (cnt1 >= CNW'(MAX_COLUMNS));

    inside_row_next    = still_open;
    open_start_next    = have_cell ? pos1 : start;
    cells_in_row_next  = have_cell ? cnt1 : cnt;
    byte_position_next = pos1;
    halted_next        = 1'b0;

    emit                = have_cell;
    result.cell_offset  = CELL_OFFSET_W'(start);
    result.cell_length  = CELL_LENGTH_W'(byte_position - start);
    result.column_index = COLUMN_W'(cnt);
    result.row_end      = line_end;
    result.status       = STATUS_CELL;

    if (too_many) begin
      result.status = STATUS_TOO_MANY;
      halted_next   = 1'b1;
    end else if (head.tok.eof && still_open) begin
      emit                = 1'b1;
      result.cell_offset  = CELL_OFFSET_W'(open_start_next);
      result.cell_length  = CELL_LENGTH_W'(pos1 - open_start_next);
      result.column_index = COLUMN_W'(cells_in_row_next);
      result.row_end      = 1'b0;
      result.status       = STATUS_NO_EOL;
      halted_next         = 1'b1;
    end else if (head.tok.eof) begin
      byte_position_next = '0;
      open_start_next    = '0;
      cells_in_row_next  = '0;
      inside_row_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      open_start    <= '0;
      cells_in_row  <= '0;
      inside_row    <= 1'b0;
      halted        <= 1'b0;
      cell_valid    <= 1'b0;
    end else begin
      if (pop && !halted) begin
        byte_position <= byte_position_next;
        open_start    <= open_start_next;
        cells_in_row  <= cells_in_row_next;
        inside_row    <= inside_row_next;
        halted        <= halted_next;
      end
      if (pop && !halted && emit) begin
        cell_valid <= 1'b1;
      end else if (cell_valid && !cell_stall) begin
        cell_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !halted && emit) begin
      cell_req <= result;
    end
  end

endmodule

/* sv/csvcs_checker.sv */
module csvcs_checker
  import csvcs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        delim_we,
  input logic [7:0]  delim_data,
  input logic        byte_valid,
  input logic        byte_stall,
  input csvcs_byte_t byte_req,
  input logic        cell_valid,
  input logic        cell_stall,
  input csvcs_cell_t cell_req
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_stall |=> cell_valid && $stable(cell_req))
    else $error("stalled cell request changed");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall && cell_req.status != STATUS_CELL |=> !cell_valid)
    else $error("result after error");

  a_reset: assert property (@(posedge clk)
    rst |=> !cell_valid)
    else $error("cell valid after reset");

  a_no_eol: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_req.status == STATUS_NO_EOL |-> !cell_req.row_end)
    else $error("missing line end result marks row end");

endmodule

bind csv_cell_splitter csvcs_checker u_chk (.*);
